### rtl/mcg_pkg.sv
// Shared types and codes for the midpoint circle cell generator.
package mcg_pkg;

   // Request kinds carried in req_tuser
   localparam logic FUNC_START = 1'b0;
   localparam logic FUNC_TICK  = 1'b1;

   // Mirror image that closes one walk point
   localparam logic [2:0] MIRROR_LAST = 3'd7;

   // Status that travels with each computed cell
   typedef struct packed {
      logic cell_valid;
      logic last;
      logic done_res;
   } rsp_flags_type;

endpackage

### rtl/mcg_walk.sv
// Circle walk state and the single-pass next-cell logic.
module mcg_walk #(
   parameter int COORD_BITS = 16,
   parameter int COUNT_BITS = 18
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         item_fire,
   input  logic                         func,
   input  logic signed [COORD_BITS-1:0] center_x,
   input  logic signed [COORD_BITS-1:0] center_y,
   input  logic signed [COORD_BITS-1:0] radius,
   input  logic        [COUNT_BITS-1:0] cell_limit,
   output logic signed [COORD_BITS:0]   cell_x_in,
   output logic signed [COORD_BITS:0]   cell_y_in,
   output mcg_pkg::rsp_flags_type       flags_in
);

   localparam int DEC_BITS = COORD_BITS + 4;

   logic signed [COORD_BITS-1:0] center_x_ff, center_x_in;
   logic signed [COORD_BITS-1:0] center_y_ff, center_y_in;
   logic signed [COORD_BITS-1:0] walk_x_ff, walk_x_in;
   logic signed [COORD_BITS-1:0] walk_y_ff, walk_y_in;
   logic signed [DEC_BITS-1:0]   decision_ff, decision_in;
   logic        [2:0]            mirror_ff, mirror_in;
   logic        [COUNT_BITS-1:0] count_ff, count_in;
   logic        [COUNT_BITS-1:0] limit_ff, limit_in;
   logic                         active_ff, active_in;

   logic signed [COORD_BITS-1:0] sel_a, sel_b;
   logic signed [COORD_BITS:0]   off_a, off_b;
   logic signed [COORD_BITS-1:0] walk_x_step, walk_y_step;
   logic signed [COORD_BITS:0]   walk_diff;
   logic signed [DEC_BITS-1:0]   decision_inc, decision_dec;
   logic        [COUNT_BITS-1:0] count_step;
   logic                         last_cell;

   // Pick and mirror the current octant point
   always_comb begin
      sel_a = mirror_ff[2] ? walk_y_ff : walk_x_ff;
      sel_b = mirror_ff[2] ? walk_x_ff : walk_y_ff;
      off_a = {sel_a[COORD_BITS-1], sel_a};
      off_b = {sel_b[COORD_BITS-1], sel_b};
      if (mirror_ff[0]) begin
         off_a = -off_a;
      end
      if (mirror_ff[1]) begin
         off_b = -off_b;
      end
   end

   // Advance the walk point and the decision value
   assign walk_y_step  = walk_y_ff + COORD_BITS'(1);
   assign walk_x_step  = walk_x_ff - COORD_BITS'(1);
   assign walk_diff    = {walk_y_step[COORD_BITS-1], walk_y_step}
                       - {walk_x_step[COORD_BITS-1], walk_x_step};
   assign decision_inc = decision_ff
                       + {{3{walk_y_step[COORD_BITS-1]}}, walk_y_step, 1'b0}
                       + DEC_BITS'(1);
   assign decision_dec = decision_ff
                       + {{2{walk_diff[COORD_BITS]}}, walk_diff, 1'b0}
                       + DEC_BITS'(1);
   assign count_step   = count_ff + COUNT_BITS'(1);

   // Next state and the result of this item
   always_comb begin
      center_x_in = center_x_ff;
      center_y_in = center_y_ff;
      walk_x_in   = walk_x_ff;
      walk_y_in   = walk_y_ff;
      decision_in = decision_ff;
      mirror_in   = mirror_ff;
      count_in    = count_ff;
      limit_in    = limit_ff;
      active_in   = active_ff;
      last_cell   = 1'b0;
      cell_x_in   = '0;
      cell_y_in   = '0;
      flags_in.cell_valid = 1'b0;
      if (func == mcg_pkg::FUNC_START) begin
         center_x_in = center_x;
         center_y_in = center_y;
         limit_in    = cell_limit;
         walk_x_in   = radius;
         walk_y_in   = '0;
         decision_in = DEC_BITS'(1) - {{4{radius[COORD_BITS-1]}}, radius};
         mirror_in   = '0;
         count_in    = '0;
         active_in   = !radius[COORD_BITS-1] && (cell_limit != '0);
      end else if (active_ff) begin
         cell_x_in = {center_x_ff[COORD_BITS-1], center_x_ff} + off_a;
         cell_y_in = {center_y_ff[COORD_BITS-1], center_y_ff} + off_b;
         flags_in.cell_valid = 1'b1;
         count_in = count_step;
         if (mirror_ff == mcg_pkg::MIRROR_LAST) begin
            mirror_in = '0;
            walk_y_in = walk_y_step;
            if (decision_ff[DEC_BITS-1]) begin
               decision_in = decision_inc;
               last_cell   = walk_x_ff < walk_y_step;
            end else begin
               walk_x_in   = walk_x_step;
               decision_in = decision_dec;
               last_cell   = walk_x_step < walk_y_step;
            end
         end else begin
            mirror_in = mirror_ff + 3'd1;
         end
         if (count_step == limit_ff) begin
            last_cell = 1'b1;
         end
         if (last_cell) begin
            active_in = 1'b0;
         end
      end
      flags_in.last     = last_cell;
      flags_in.done_res = !active_in;
   end

   // Hold walk state; update on each accepted item
   always_ff @(posedge clock) begin
      if (reset) begin
         center_x_ff <= '0;
         center_y_ff <= '0;
         walk_x_ff   <= '0;
         walk_y_ff   <= '0;
         decision_ff <= '0;
         mirror_ff   <= '0;
         count_ff    <= '0;
         limit_ff    <= '0;
         active_ff   <= 1'b0;
      end else if (item_fire) begin
         center_x_ff <= center_x_in;
         center_y_ff <= center_y_in;
         walk_x_ff   <= walk_x_in;
         walk_y_ff   <= walk_y_in;
         decision_ff <= decision_in;
         mirror_ff   <= mirror_in;
         count_ff    <= count_in;
         limit_ff    <= limit_in;
         active_ff   <= active_in;
      end
   end

endmodule

### rtl/mcg_rsp_reg.sv
// Result register that holds one item toward the result channel.
module mcg_rsp_reg #(
   parameter int COORD_BITS = 16,
   parameter int DATA_W     = 40
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       load,
   input  logic signed [COORD_BITS:0] cell_x_in,
   input  logic signed [COORD_BITS:0] cell_y_in,
   input  mcg_pkg::rsp_flags_type     flags_in,
   output logic                       take_ok,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [DATA_W-1:0]          rsp_tdata,
   output logic                       rsp_tuser,
   output logic                       rsp_tlast
);

   logic                       valid_ff;
   logic signed [COORD_BITS:0] cell_x_ff;
   logic signed [COORD_BITS:0] cell_y_ff;
   mcg_pkg::rsp_flags_type     flags_ff;

   // Room for a new item when empty or when the held item leaves now
   assign take_ok = !valid_ff || rsp_tready;

   // Hold valid until taken
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (take_ok) begin
         valid_ff <= load;
      end
   end

   // Capture payload
   always_ff @(posedge clock) begin
      if (load && take_ok) begin
         cell_x_ff <= cell_x_in;
         cell_y_ff <= cell_y_in;
         flags_ff  <= flags_in;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = DATA_W'({flags_ff.done_res, cell_y_ff, cell_x_ff});
   assign rsp_tuser  = flags_ff.cell_valid;
   assign rsp_tlast  = flags_ff.last;

endmodule

### rtl/midpoint_circle_cell_generator.sv
// Top level of the midpoint circle outline cell generator.
//
//  channel  direction  tdata (low bit up)                          tuser       tlast
//  req      in         center_x, center_y, radius, cell_limit      func        -
//  rsp      out        cell_x, cell_y, done_res                    cell_valid  last
//
// The walk state and the next cell of an item are computed in one pass and written
// to the result register on the accepting edge, so one item a clock is sustained
// while rsp_tready stays high.
// Reset clears the walk state to idle and empties the result register.
// A stalled result holds its register; req_tready drops until it is taken.
module midpoint_circle_cell_generator #(
   parameter int COORD_BITS = 16,
   parameter int COUNT_BITS = 18
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // center_x, center_y, radius, cell_limit, zero fill
   input  logic [((3*COORD_BITS+COUNT_BITS+7)/8)*8-1:0] req_tdata,
   // func
   input  logic                  req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // cell_x, cell_y, done_res, zero fill
   output logic [((2*COORD_BITS+3+7)/8)*8-1:0] rsp_tdata,
   // cell_valid
   output logic                  rsp_tuser,
   output logic                  rsp_tlast
);

   localparam int RSP_DATA_W = ((2*COORD_BITS+3+7)/8)*8;

   logic                         item_fire;
   logic                         take_ok;
   logic signed [COORD_BITS:0]   cell_x_in;
   logic signed [COORD_BITS:0]   cell_y_in;
   mcg_pkg::rsp_flags_type       flags_in;

   assign req_tready = take_ok;
   assign item_fire  = req_tvalid && take_ok;

   // Walk state and cell computation
   mcg_walk #(
      .COORD_BITS (COORD_BITS),
      .COUNT_BITS (COUNT_BITS)
   ) u_walk (
      .clock      (clock),
      .reset      (reset),
      .item_fire  (item_fire),
      .func       (req_tuser),
      .center_x   (req_tdata[COORD_BITS-1:0]),
      .center_y   (req_tdata[2*COORD_BITS-1:COORD_BITS]),
      .radius     (req_tdata[3*COORD_BITS-1:2*COORD_BITS]),
      .cell_limit (req_tdata[3*COORD_BITS+COUNT_BITS-1:3*COORD_BITS]),
      .cell_x_in  (cell_x_in),
      .cell_y_in  (cell_y_in),
      .flags_in   (flags_in)
   );

   // Result register
   mcg_rsp_reg #(
      .COORD_BITS (COORD_BITS),
      .DATA_W     (RSP_DATA_W)
   ) u_rsp_reg (
      .clock      (clock),
      .reset      (reset),
      .load       (item_fire),
      .cell_x_in  (cell_x_in),
      .cell_y_in  (cell_y_in),
      .flags_in   (flags_in),
      .take_ok    (take_ok),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

`ifndef NO_ASSERTIONS
   // A last cell is always a real cell and leaves the generator idle
   a_last_is_cell: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tuser && rsp_tdata[2*COORD_BITS+2])
      else $error("last item without a cell or without idle status");

   // An item without a cell carries zero coordinates
   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata[2*COORD_BITS+1:0] == '0)
      else $error("empty item carries coordinates");

   // An accepted item shows up as a result in the next cycle
   a_item_lands: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> rsp_tvalid)
      else $error("accepted item produced no result");

   // Nothing is offered right after reset
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result offered after reset");
`endif

endmodule
